/* hw/rtl/bipartite_scc_fixed_cells_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef BIPARTITE_SCC_FIXED_CELLS_MACROS_SVH
`define BIPARTITE_SCC_FIXED_CELLS_MACROS_SVH

`ifndef SYNTHESIS
// Condition and consequence in the same cycle
`define BSCC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Consequence in the cycle after the condition
`define BSCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BSCC_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define BSCC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/bscc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bscc_pkg;

   // Matrix geometry
   localparam int MAX_ROWS = 32;
   localparam int MAX_COLS = 32;
   localparam int NUM_VERT = MAX_ROWS + MAX_COLS;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int STEP_W   = $clog2(NUM_VERT);
   localparam int SIZE_W   = 6;
   localparam int DATA_W   = 32;

   // Register indexes
   localparam logic CSR_NUM_ROWS = 1'b0;
   localparam logic CSR_NUM_COLS = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic store_wr;
      logic build;
      logic close_step;
      logic emit_load;
   } bscc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic job_done;
      logic out_free;
      logic emit_last;
   } bscc_stat_type;

endpackage
`default_nettype wire

/* hw/rtl/bscc_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
module bscc_controller (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  bscc_pkg::bscc_stat_type stat,
   output bscc_pkg::bscc_cmd_type  cmd
);
   import bscc_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_BUILD = 2'd1;
   localparam logic [1:0] S_CLOSE = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // commands
   always_comb begin
      req_ready      = (state_ff == S_IDLE);
      cmd.store_wr   = (state_ff == S_IDLE) && req_valid;
      cmd.build      = (state_ff == S_BUILD);
      cmd.close_step = (state_ff == S_CLOSE);
      cmd.emit_load  = (state_ff == S_EMIT) && stat.out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && stat.job_done) begin
               state_in = S_BUILD;
            end
         end
         S_BUILD: begin
            state_in = S_CLOSE;
            step_in  = '0;
         end
         S_CLOSE: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(NUM_VERT - 1)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.out_free && stat.emit_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/bscc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module bscc_datapath (
   input  wire                           clock,
   input  wire                           reset,
   input  bscc_pkg::bscc_cmd_type        cmd,
   output bscc_pkg::bscc_stat_type       stat,
   input  wire                           csr_wr_en,
   input  wire                           csr_index,
   input  wire  [bscc_pkg::SIZE_W-1:0]   csr_wr_data,
   input  wire  [bscc_pkg::DATA_W-1:0]   req_entry_bits,
   input  wire  [bscc_pkg::DATA_W-1:0]   req_fixed_bits,
   input  wire                           rsp_ready,
   output logic                          rsp_valid,
   output logic [bscc_pkg::ROW_W-1:0]    rsp_row_number,
   output logic [bscc_pkg::DATA_W-1:0]   rsp_fixed_out_bits,
   output logic                          rsp_last_row
);
   import bscc_pkg::*;

   logic [SIZE_W-1:0]   num_rows_ff, num_cols_ff;
   logic [SIZE_W-1:0]   rows_loaded_ff, rows_loaded_in;
   logic [SIZE_W-1:0]   nr_eff, nc_eff, rows_next;
   logic                job_done;
   logic [DATA_W-1:0]   entry_store_ff [MAX_ROWS];
   logic [DATA_W-1:0]   fixed_store_ff [MAX_ROWS];
   logic [NUM_VERT-1:0] reach_ff [NUM_VERT];
   logic [NUM_VERT-1:0] reach_init [NUM_VERT];
   logic [NUM_VERT-1:0] reach_step [NUM_VERT];
   logic [NUM_VERT-1:0] reach_upd  [NUM_VERT];
   logic [ROW_W-1:0]    emit_cnt_ff;
   logic [MAX_ROWS-1:0] row_ok;
   logic [MAX_COLS-1:0] col_ok;
   logic [NUM_VERT-1:0] sel_reach;
   logic [MAX_COLS-1:0] col_back;
   logic [DATA_W-1:0]   fixed_out;
   logic                rsp_valid_ff;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic [DATA_W-1:0]   rsp_bits_ff;
   logic                rsp_last_ff;

   // effective sizes: zero acts as one, capped at the maximum
   always_comb begin
      if (num_rows_ff == '0) begin
         nr_eff = SIZE_W'(1);
      end else if (num_rows_ff > SIZE_W'(MAX_ROWS)) begin
         nr_eff = SIZE_W'(MAX_ROWS);
      end else begin
         nr_eff = num_rows_ff;
      end
      if (num_cols_ff == '0) begin
         nc_eff = SIZE_W'(1);
      end else if (num_cols_ff > SIZE_W'(MAX_COLS)) begin
         nc_eff = SIZE_W'(MAX_COLS);
      end else begin
         nc_eff = num_cols_ff;
      end
      for (int i = 0; i < MAX_ROWS; i++) begin
         row_ok[i] = SIZE_W'(i) < nr_eff;
      end
      for (int j = 0; j < MAX_COLS; j++) begin
         col_ok[j] = SIZE_W'(j) < nc_eff;
      end
   end

   // row counting
   always_comb begin
      rows_next      = rows_loaded_ff + SIZE_W'(1);
      job_done       = (rows_next >= nr_eff);
      rows_loaded_in = job_done ? '0 : rows_next;
   end

   // config registers and row counter
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff    <= SIZE_W'(MAX_ROWS);
         num_cols_ff    <= SIZE_W'(MAX_COLS);
         rows_loaded_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_NUM_ROWS: num_rows_ff <= csr_wr_data;
               CSR_NUM_COLS: num_cols_ff <= csr_wr_data;
               default: ;
            endcase
         end
         if (cmd.store_wr) begin
            rows_loaded_ff <= rows_loaded_in;
         end
      end
   end

   // row stores
   always_ff @(posedge clock) begin
      if (cmd.store_wr) begin
         entry_store_ff[rows_loaded_ff[ROW_W-1:0]] <= req_entry_bits;
         fixed_store_ff[rows_loaded_ff[ROW_W-1:0]] <= req_fixed_bits;
      end
   end

   // initial adjacency: row i -> column j on open 0, column j -> row i on open 1
   always_comb begin
      for (int v = 0; v < NUM_VERT; v++) begin
         reach_init[v] = '0;
      end
      for (int i = 0; i < MAX_ROWS; i++) begin
         reach_init[i][i] = row_ok[i];
      end
      for (int j = 0; j < MAX_COLS; j++) begin
         reach_init[MAX_ROWS + j][MAX_ROWS + j] = col_ok[j];
      end
      for (int i = 0; i < MAX_ROWS; i++) begin
         for (int j = 0; j < MAX_COLS; j++) begin
            reach_init[i][MAX_ROWS + j] = row_ok[i] && col_ok[j] &&
               !fixed_store_ff[i][j] && !entry_store_ff[i][j];
            reach_init[MAX_ROWS + j][i] = row_ok[i] && col_ok[j] &&
               !fixed_store_ff[i][j] && entry_store_ff[i][j];
         end
      end
   end

   // one closure pivot per cycle; pivot row and column always sit at
   // position 0, and the lanes rotate by one so the next vertex moves in
   genvar gu;
   generate
      for (gu = 0; gu < NUM_VERT; gu++) begin : g_lane
         localparam int NXT = (gu == NUM_VERT - 1) ? 0 : gu + 1;
         assign reach_upd[gu]  = reach_ff[gu][0] ? (reach_ff[gu] | reach_ff[0])
                                                 : reach_ff[gu];
         assign reach_step[gu] = {reach_upd[NXT][0], reach_upd[NXT][NUM_VERT-1:1]};
      end
   endgenerate

   always_ff @(posedge clock) begin
      for (int v = 0; v < NUM_VERT; v++) begin
         if (cmd.build) begin
            reach_ff[v] <= reach_init[v];
         end else if (cmd.close_step) begin
            reach_ff[v] <= reach_step[v];
         end
      end
   end

   // emitted row: set marks where row and column lie in different components
   always_comb begin
      sel_reach = reach_ff[STEP_W'(emit_cnt_ff)];
      for (int j = 0; j < MAX_COLS; j++) begin
         col_back[j] = reach_ff[MAX_ROWS + j][STEP_W'(emit_cnt_ff)];
      end
      fixed_out = fixed_store_ff[emit_cnt_ff] |
                  DATA_W'(col_ok & ~(sel_reach[MAX_ROWS +: MAX_COLS] & col_back));
      stat.job_done  = job_done;
      stat.emit_last = (SIZE_W'(emit_cnt_ff) + SIZE_W'(1)) == nr_eff;
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // emit counter and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.build) begin
            emit_cnt_ff <= '0;
         end else if (cmd.emit_load) begin
            emit_cnt_ff <= emit_cnt_ff + ROW_W'(1);
         end
         if (cmd.emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_row_ff  <= emit_cnt_ff;
         rsp_bits_ff <= fixed_out;
         rsp_last_ff <= stat.emit_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_row_number     = rsp_row_ff;
   assign rsp_fixed_out_bits = rsp_bits_ff;
   assign rsp_last_row       = rsp_last_ff;

endmodule
`default_nettype wire

/* hw/rtl/bipartite_scc_fixed_cells.sv */
`timescale 1ns / 1ps
`default_nettype none
// Fixed-cell propagation over a binary matrix of up to 32 x 32. Rows arrive one
// request each; every request that does not complete the job is taken while
// the block is idle. The request that completes the job (num_rows rows, or as
// soon as the row count in force is reached) starts the build state that forms
// the bipartite row/column graph, then the closure state, one pivot vertex per
// cycle applied across 64 vertex lanes, then one result per row at up to one
// per cycle while rsp_ready allows. Requests are held off from the completing
// row until the last result is in the output register. A result carries the
// row's fixed marks with every in-use column set whose vertex lies in a
// different strongly connected component from the row; columns past num_cols
// pass through unchanged. Configuration is to be written only while the block
// is idle, by the user; the block itself does not enforce this.
`include "bipartite_scc_fixed_cells_macros.svh"
module bipartite_scc_fixed_cells (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_wr_en,
   input  wire                         csr_index,
   input  wire  [bscc_pkg::SIZE_W-1:0] csr_wr_data,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire  [bscc_pkg::DATA_W-1:0] req_entry_bits,
   input  wire  [bscc_pkg::DATA_W-1:0] req_fixed_bits,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [bscc_pkg::ROW_W-1:0]  rsp_row_number,
   output logic [bscc_pkg::DATA_W-1:0] rsp_fixed_out_bits,
   output logic                        rsp_last_row
);
   import bscc_pkg::*;

   bscc_cmd_type  cmd;
   bscc_stat_type stat;

   bscc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bscc_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_entry_bits     (req_entry_bits),
      .req_fixed_bits     (req_fixed_bits),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_row_number     (rsp_row_number),
      .rsp_fixed_out_bits (rsp_fixed_out_bits),
      .rsp_last_row       (rsp_last_row)
   );

   // no request taken while the closure runs
   `BSCC_ASSERT_NOW(a_no_req_in_close, clock, reset, cmd.close_step, !req_ready)
   // completing row goes straight to the build cycle
   `BSCC_ASSERT_NEXT(a_done_builds, clock, reset,
                     req_valid && req_ready && stat.job_done, !req_ready && cmd.build)
   // a waiting result stays put until taken
   `BSCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_row_number))

endmodule
`default_nettype wire
